[design/ipfixd_pkg.sv]
`default_nettype none

package ipfixd_pkg;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [4:0] {
    EV_SESS_START  = 5'd0,
    EV_MSG_START   = 5'd1,
    EV_TMPL_START  = 5'd2,
    EV_OPT_START   = 5'd3,
    EV_DATA_START  = 5'd4,
    EV_BODY        = 5'd5,
    EV_TMPL_END    = 5'd6,
    EV_OPT_END     = 5'd7,
    EV_DATA_END    = 5'd8,
    EV_MSG_END     = 5'd9,
    EV_SESS_END    = 5'd10,
    EV_SHORT_HDR   = 5'd11,
    EV_BAD_VER     = 5'd12,
    EV_SHORT_BODY  = 5'd13,
    EV_LONG_SET    = 5'd14,
    EV_BAD_ID      = 5'd15,
    EV_BAD_LEN     = 5'd16
  } ev_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  event_res;
    logic [7:0]  body_byte;
    logic [15:0] set_id;
    logic [15:0] length;
    logic [31:0] export_time;
    logic [31:0] sequence_number;
    logic [31:0] domain_id;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]        num;
    res_t [MaxRes-1:0] res;
  } batch_t;

endpackage

`default_nettype wire

[design/ipfix_message_set_deframer.sv]
// An accepted request waits in an input register until the result queue has room,
// then its results are decoded into the queue. Throughput: one request per cycle
// while each request yields at most one result and the output is not stalled; the
// four-entry result queue throttles the input when it cannot hold three more results.
// Reset is asynchronous and active low; it leaves the block idle with no session open.
`default_nettype none

module ipfix_message_set_deframer import ipfixd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output res_t          out_o
);

  logic     in_valid_q, in_valid_d;
  in_item_t in_q;
  logic     room;
  logic     advance;
  batch_t   batch;

  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  ipfixd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (advance),
    .item_i  (in_q),
    .batch_o (batch)
  );

  ipfixd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[design/ipfixd_core.sv]
`default_nettype none

module ipfixd_core import ipfixd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire in_item_t item_i,
  output batch_t        batch_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR   = 3'd1,
    PH_SHDR  = 3'd2,
    PH_SBODY = 3'd3,
    PH_SKIP  = 3'd4,
    PH_HALT  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CLS_TMPL = 2'd0,
    CLS_OPT  = 2'd1,
    CLS_DATA = 2'd2
  } cls_e;

  phase_e       phase_q, phase_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [119:0] hs_q, hs_d;
  logic [15:0]  mr_q, mr_d;
  logic [15:0]  sr_q, sr_d;
  logic [15:0]  sid_q, sid_d;
  cls_e         cls_q, cls_d;

  function automatic res_t mk(input ev_e e, input logic [7:0] bb, input logic [15:0] sid,
                              input logic [15:0] len, input logic [31:0] t,
                              input logic [31:0] s, input logic [31:0] d);
    res_t r;
    r.event_res       = e;
    r.body_byte       = bb;
    r.set_id          = sid;
    r.length          = len;
    r.export_time     = t;
    r.sequence_number = s;
    r.domain_id       = d;
    r.last            = 1'b0;
    return r;
  endfunction

  function automatic ev_e start_ev(input cls_e c);
    ev_e e;
    case (c)
      CLS_TMPL: e = EV_TMPL_START;
      CLS_OPT:  e = EV_OPT_START;
      default:  e = EV_DATA_START;
    endcase
    return e;
  endfunction

  function automatic ev_e end_ev(input cls_e c);
    ev_e e;
    case (c)
      CLS_TMPL: e = EV_TMPL_END;
      CLS_OPT:  e = EV_OPT_END;
      default:  e = EV_DATA_END;
    endcase
    return e;
  endfunction

  always_comb begin
    logic [7:0]   b;
    logic [127:0] hdr;
    logic [15:0]  mr_dec, sr_dec, slen, slen_c, nb_mr;
    logic [3:0]   cnt_cur;
    logic         nb;
    logic [1:0]   n;
    phase_e       ph;
    cls_e         cls;
    res_t [MaxRes-1:0] res;

    b       = item_i.data_byte;
    hdr     = {hs_q, b};
    mr_dec  = mr_q - 16'd1;
    sr_dec  = sr_q - 16'd1;
    slen    = {sr_q[7:0], b};
    slen_c  = slen - 16'd4;
    cnt_cur = cnt_q;
    nb      = 1'b0;
    nb_mr   = '0;
    n       = '0;
    res     = '0;
    cls     = CLS_DATA;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hs_d    = hs_q;
    mr_d    = mr_q;
    sr_d    = sr_q;
    sid_d   = sid_q;
    cls_d   = cls_q;
    ph      = phase_q;

    if (valid_i) begin
      if (ph == PH_IDLE) begin
        res[n] = mk(EV_SESS_START, '0, '0, '0, '0, '0, '0);
        n = n + 2'd1;
        cnt_d = '0;
        ph = PH_HDR;
        phase_d = PH_HDR;
      end
      cnt_cur = cnt_d;
      if (item_i.kind) begin
        case (ph)
          PH_HDR: begin
            res[n] = mk((cnt_cur == 4'd0) ? EV_SESS_END : EV_SHORT_HDR,
                        '0, '0, '0, '0, '0, '0);
            n = n + 2'd1;
          end
          PH_SHDR, PH_SBODY, PH_SKIP: begin
            res[n] = mk(EV_SHORT_BODY, '0, '0, '0, '0, '0, '0);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
        phase_d = PH_IDLE;
        cnt_d = '0;
      end else begin
        case (ph)
          PH_HDR: begin
            hs_d = {hs_q[111:0], b};
            cnt_d = cnt_cur + 4'd1;
            if (cnt_cur == 4'd15) begin
              if (hdr[127:112] != 16'd10) begin
                res[n] = mk(EV_BAD_VER, '0, '0, '0, '0, '0, '0);
                n = n + 2'd1;
                phase_d = PH_HALT;
              end else if (hdr[111:96] < 16'd16) begin
                res[n] = mk(EV_BAD_LEN, '0, '0, '0, '0, '0, '0);
                n = n + 2'd1;
                phase_d = PH_HALT;
              end else begin
                res[n] = mk(EV_MSG_START, '0, '0, hdr[111:96], hdr[95:64], hdr[63:32],
                            hdr[31:0]);
                n = n + 2'd1;
                mr_d = hdr[111:96] - 16'd16;
                nb = 1'b1;
                nb_mr = hdr[111:96] - 16'd16;
              end
            end
          end
          PH_SHDR: begin
            mr_d = mr_dec;
            if (cnt_cur < 4'd2) begin
              sid_d = {sid_q[7:0], b};
            end else begin
              sr_d = slen;
            end
            cnt_d = cnt_cur + 4'd1;
            if (cnt_cur == 4'd3) begin
              if (slen < 16'd4) begin
                res[n] = mk(EV_BAD_LEN, '0, sid_q, '0, '0, '0, '0);
                n = n + 2'd1;
                phase_d = PH_HALT;
              end else if (slen_c > mr_dec) begin
                sr_d = slen_c;
                res[n] = mk(EV_LONG_SET, '0, sid_q, '0, '0, '0, '0);
                n = n + 2'd1;
                phase_d = PH_HALT;
              end else if (sid_q != 16'd2 && sid_q != 16'd3 && sid_q < 16'd256) begin
                sr_d = slen_c;
                res[n] = mk(EV_BAD_ID, '0, sid_q, '0, '0, '0, '0);
                n = n + 2'd1;
                phase_d = PH_HALT;
              end else begin
                if (sid_q == 16'd2) begin
                  cls = CLS_TMPL;
                end else if (sid_q == 16'd3) begin
                  cls = CLS_OPT;
                end
                cls_d = cls;
                sr_d = slen_c;
                cnt_d = '0;
                res[n] = mk(start_ev(cls), '0, sid_q, slen_c, '0, '0, '0);
                n = n + 2'd1;
                if (slen_c == 16'd0) begin
                  res[n] = mk(end_ev(cls), '0, sid_q, '0, '0, '0, '0);
                  n = n + 2'd1;
                  nb = 1'b1;
                  nb_mr = mr_dec;
                end else begin
                  phase_d = PH_SBODY;
                end
              end
            end
          end
          PH_SBODY: begin
            res[n] = mk(EV_BODY, b, sid_q, '0, '0, '0, '0);
            n = n + 2'd1;
            mr_d = mr_dec;
            sr_d = sr_dec;
            if (sr_dec == 16'd0) begin
              res[n] = mk(end_ev(cls_q), '0, sid_q, '0, '0, '0, '0);
              n = n + 2'd1;
              nb = 1'b1;
              nb_mr = mr_dec;
            end
          end
          PH_SKIP: begin
            mr_d = mr_dec;
            if (mr_dec == 16'd0) begin
              nb = 1'b1;
              nb_mr = '0;
            end
          end
          default: begin
          end
        endcase
      end

      if (nb) begin
        cnt_d = '0;
        if (nb_mr == 16'd0) begin
          res[n] = mk(EV_MSG_END, '0, '0, '0, '0, '0, '0);
          n = n + 2'd1;
          phase_d = PH_HDR;
        end else if (nb_mr < 16'd4) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d = PH_SHDR;
        end
      end
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    batch_o.num = n;
    batch_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      mr_q    <= '0;
      sr_q    <= '0;
      sid_q   <= '0;
      cls_q   <= CLS_TMPL;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      mr_q    <= mr_d;
      sr_q    <= sr_d;
      sid_q   <= sid_d;
      cls_q   <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hs_q <= hs_d;
  end

`ifndef SYNTH
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !item_i.kind && phase_q == PH_HALT) |-> (batch_o.num == 2'd0))
    else $error("halted block produced a result for a stream byte");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_o.num == 2'd3) |-> (batch_o.res[2].last && !batch_o.res[1].last
                               && !batch_o.res[0].last))
    else $error("last flag misplaced in a full batch");
`endif

endmodule

`default_nettype wire

[design/ipfixd_res_fifo.sv]
`default_nettype none

module ipfixd_res_fifo import ipfixd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire batch_t batch_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output res_t        out_o
);

  res_t       mem_q [FifoDepth];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= 3'd1) || ((cnt_q == 3'd2) && pop);

  always_comb begin
    wr_d  = wr_q + batch_i.num;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, batch_i.num} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < batch_i.num) begin
        mem_q[wr_q + 2'(k)] <= batch_i.res[k];
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_i.num == 2'd0 && !pop) |=> (cnt_q == $past(cnt_q)))
    else $error("result queue count moved without a push or pop");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ipfixd_pkg::*;

  localparam int unsigned HangLimit = 1000;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_HEADER     = 3'd1,
    PH_SET_HEADER = 3'd2,
    PH_SET_BODY   = 3'd3,
    PH_SKIP       = 3'd4,
    PH_HALTED     = 3'd5
  } phase_e;

  typedef enum int unsigned {
    FLAW_VERSION,
    FLAW_MSG_LEN,
    FLAW_SET_LEN,
    FLAW_SET_ID,
    FLAW_LONG_SET,
    FLAW_TRUNCATE,
    FLAW_NONE
  } flaw_e;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_item_t in_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  res_t     out_o;

  ipfix_message_set_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Deframer state as predicted from the accepted requests.
  phase_e      ph = PH_IDLE;
  logic [7:0]  hdr_bytes [16];
  logic [4:0]  hdr_count = '0;
  logic [15:0] msg_left = '0;
  logic [15:0] set_left = '0;
  logic [15:0] cur_set_id = '0;
  logic [1:0]  set_cls = '0;

  res_t        pending_events[$];
  in_item_t    stream_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent_count = 0;
  bit          no_gaps = 1'b0;

  function automatic void push_event(ev_e code, logic [7:0] b, logic [15:0] sid);
    res_t r;
    r = '0;
    r.event_res = code;
    r.body_byte = b;
    r.set_id = sid;
    pending_events.push_back(r);
  endfunction

  function automatic void next_in_body();
    hdr_count = '0;
    if (msg_left == 16'd0) begin
      push_event(EV_MSG_END, 8'd0, 16'd0);
      ph = PH_HEADER;
    end else if (msg_left < 16'd4) begin
      ph = PH_SKIP;
    end else begin
      ph = PH_SET_HEADER;
    end
  endfunction

  function automatic void close_set();
    push_event(ev_e'(EV_TMPL_END + set_cls), 8'd0, cur_set_id);
    next_in_body();
  endfunction

  function automatic void take_set_header(logic [7:0] b);
    res_t r;
    msg_left = msg_left - 16'd1;
    if (hdr_count < 5'd2) cur_set_id = {cur_set_id[7:0], b};
    else set_left = {set_left[7:0], b};
    hdr_count = hdr_count + 5'd1;
    if (hdr_count != 5'd4) return;
    // A short set length is checked before the length against the message.
    if (set_left < 16'd4) begin
      push_event(EV_BAD_LEN, 8'd0, cur_set_id);
      ph = PH_HALTED;
      return;
    end
    set_left = set_left - 16'd4;
    if (set_left > msg_left) begin
      push_event(EV_LONG_SET, 8'd0, cur_set_id);
      ph = PH_HALTED;
    end else if (cur_set_id == 16'd2 || cur_set_id == 16'd3 || cur_set_id >= 16'd256) begin
      set_cls = (cur_set_id >= 16'd256) ? 2'd2 : 2'(cur_set_id - 16'd2);
      r = '0;
      r.event_res = EV_TMPL_START + set_cls;
      r.set_id = cur_set_id;
      r.length = set_left;
      pending_events.push_back(r);
      hdr_count = '0;
      if (set_left == 16'd0) close_set();
      else ph = PH_SET_BODY;
    end else begin
      push_event(EV_BAD_ID, 8'd0, cur_set_id);
      ph = PH_HALTED;
    end
  endfunction

  function automatic void predict_events(in_item_t req);
    res_t        r;
    int unsigned first;
    logic [15:0] version;
    logic [15:0] msg_len;
    first = pending_events.size();
    if (ph == PH_IDLE) begin
      push_event(EV_SESS_START, 8'd0, 16'd0);
      hdr_count = '0;
      ph = PH_HEADER;
    end
    if (req.kind) begin
      if (ph == PH_HEADER) begin
        push_event(hdr_count == 5'd0 ? EV_SESS_END : EV_SHORT_HDR, 8'd0, 16'd0);
      end else if (ph == PH_SET_HEADER || ph == PH_SET_BODY || ph == PH_SKIP) begin
        push_event(EV_SHORT_BODY, 8'd0, 16'd0);
      end
      ph = PH_IDLE;
      hdr_count = '0;
    end else begin
      case (ph)
        PH_HEADER: begin
          hdr_bytes[hdr_count[3:0]] = req.data_byte;
          hdr_count = hdr_count + 5'd1;
          if (hdr_count == 5'd16) begin
            version = {hdr_bytes[0], hdr_bytes[1]};
            msg_len = {hdr_bytes[2], hdr_bytes[3]};
            if (version != 16'd10) begin
              push_event(EV_BAD_VER, 8'd0, 16'd0);
              ph = PH_HALTED;
            end else if (msg_len < 16'd16) begin
              push_event(EV_BAD_LEN, 8'd0, 16'd0);
              ph = PH_HALTED;
            end else begin
              r = '0;
              r.event_res = EV_MSG_START;
              r.length = msg_len;
              r.export_time = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
              r.sequence_number = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
              r.domain_id = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
              pending_events.push_back(r);
              msg_left = msg_len - 16'd16;
              next_in_body();
            end
          end
        end
        PH_SET_HEADER: take_set_header(req.data_byte);
        PH_SET_BODY: begin
          push_event(EV_BODY, req.data_byte, cur_set_id);
          msg_left = msg_left - 16'd1;
          set_left = set_left - 16'd1;
          if (set_left == 16'd0) close_set();
        end
        PH_SKIP: begin
          msg_left = msg_left - 16'd1;
          if (msg_left == 16'd0) next_in_body();
        end
        default: begin
        end
      endcase
    end
    if (pending_events.size() > first) begin
      r = pending_events.pop_back();
      r.last = 1'b1;
      pending_events.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          $error("Unexpected result with event_res %0d.", out_o.event_res);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(out_o.event_res));
          check_field("body_byte", 32'(want.body_byte), 32'(out_o.body_byte));
          check_field("set_id", 32'(want.set_id), 32'(out_o.set_id));
          check_field("length", 32'(want.length), 32'(out_o.length));
          check_field("export_time", want.export_time, out_o.export_time);
          check_field("sequence_number", want.sequence_number, out_o.sequence_number);
          check_field("domain_id", want.domain_id, out_o.domain_id);
          check_field("last", 32'(want.last), 32'(out_o.last));
        end
      end
      if (in_valid_i && !in_stall_o) predict_events(in_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= HangLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    wait (rst_ni);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
  endtask

  function automatic void put_byte(logic [7:0] b);
    stream_q.push_back(in_item_t'({1'b0, b}));
  endfunction

  function automatic void put16(logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void put_eos();
    stream_q.push_back(in_item_t'({1'b1, 8'($urandom)}));
  endfunction

  function automatic void put_header(logic [15:0] ver, logic [15:0] mlen, logic [31:0] t,
                                     logic [31:0] s, logic [31:0] d);
    put16(ver);
    put16(mlen);
    put32(t);
    put32(s);
    put32(d);
  endfunction

  task automatic send_stream();
    foreach (stream_q[i]) send_request(stream_q[i]);
    stream_q.delete();
  endtask

  task automatic test_session_marks();
    put_eos();
    put_eos();
    send_stream();
  endtask

  task automatic test_well_formed_messages();
    no_gaps = 1'b1;
    put_header(16'd10, 16'd34, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001);
    put16(16'd2);
    put16(16'd6);
    put_byte(8'h00);
    put_byte(8'hFF);
    put16(16'd3);
    put16(16'd4);
    put16(16'hFFFF);
    put16(16'd5);
    put_byte(8'hA5);
    repeat (3) put_byte(8'($urandom));
    // The last content byte closes the set and the message in one request.
    put_header(16'd10, 16'd21, 32'd1, 32'hFFFF_FFFF, 32'd0);
    put16(16'd256);
    put16(16'd5);
    put_byte(8'h5A);
    put_header(16'd10, 16'd16, 32'd7, 32'd8, 32'd9);
    put_eos();
    send_stream();
    no_gaps = 1'b0;
  endtask

  task automatic test_header_errors();
    repeat (3) put_byte(8'($urandom));
    put_eos();
    put_header(16'd9, 16'd16, 32'd0, 32'd0, 32'd0);
    put_byte(8'h0A);
    put_byte(8'hFF);
    put_eos();
    put_eos();
    put_header(16'd10, 16'd15, 32'd0, 32'd0, 32'd0);
    put_eos();
    put_header(16'd10, 16'hFFFF, 32'h1234_5678, 32'd1, 32'hFFFF_FFFF);
    put_eos();
    send_stream();
  endtask

  task automatic test_set_errors();
    put_header(16'd10, 16'd24, 32'd1, 32'd2, 32'd3);
    put16(16'd255);
    put16(16'd8);
    put_eos();
    put_header(16'd10, 16'd24, 32'd1, 32'd2, 32'd3);
    put16(16'd255);
    put16(16'd3);
    put_eos();
    put_header(16'd10, 16'd24, 32'd1, 32'd2, 32'd3);
    put16(16'd256);
    put16(16'hFFFF);
    put_eos();
    put_header(16'd10, 16'd18, 32'd1, 32'd2, 32'd3);
    put_byte(8'h11);
    put_eos();
    put_header(16'd10, 16'd28, 32'd1, 32'd2, 32'd3);
    put16(16'd3);
    put16(16'd12);
    put_byte(8'h80);
    put_byte(8'h7F);
    put_eos();
    send_stream();
  endtask

  task automatic send_random_message(input bit broken);
    logic [7:0]  body_q[$];
    int unsigned nsets;
    int unsigned clen;
    int unsigned cut;
    flaw_e       flaw;
    logic [15:0] id;
    logic [15:0] slen;
    logic [15:0] mlen;
    logic [15:0] ver;
    nsets = $urandom_range(0, 3);
    flaw = broken ? flaw_e'($urandom_range(0, 5)) : FLAW_NONE;
    for (int i = 0; i < nsets; i++) begin
      case ($urandom_range(0, 2))
        0: id = 16'd2;
        1: id = 16'd3;
        default: id = 16'($urandom_range(256, 65535));
      endcase
      clen = $urandom_range(0, 8);
      slen = 16'(clen + 4);
      if (i == 0 && flaw == FLAW_SET_ID) id = 16'($urandom_range(0, 255));
      if (i == 0 && flaw == FLAW_SET_LEN) slen = 16'($urandom_range(0, 3));
      body_q.push_back(id[15:8]);
      body_q.push_back(id[7:0]);
      body_q.push_back(slen[15:8]);
      body_q.push_back(slen[7:0]);
      repeat (clen) body_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom));
    mlen = 16'(16 + body_q.size());
    ver = 16'd10;
    case (flaw)
      FLAW_VERSION: ver = 16'($urandom_range(0, 65535)) ^ 16'(1 << $urandom_range(0, 15));
      FLAW_MSG_LEN: mlen = 16'($urandom_range(0, 15));
      FLAW_LONG_SET: if (body_q.size() > 0) mlen = mlen - 16'($urandom_range(1, 4));
      default: begin
      end
    endcase
    put_header(ver, mlen, $urandom, $urandom, $urandom);
    foreach (body_q[i]) put_byte(body_q[i]);
    if (flaw == FLAW_TRUNCATE) begin
      cut = $urandom_range(1, stream_q.size() - 1);
      stream_q = stream_q[0:cut-1];
    end
    if (broken) put_eos();
    send_stream();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
    put_eos();
    send_stream();
  endtask

  task automatic test_random_streams();
    int unsigned goal;
    int unsigned pick;
    goal = 300;
    while (sent_count < goal) begin
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      pick = $urandom_range(0, 9);
      if (pick < 7) send_random_message(1'b0);
      else if (pick < 9) send_random_message(1'b1);
      else send_noise();
      if ($urandom_range(0, 3) == 0) begin
        put_eos();
        send_stream();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_session_marks();
    test_well_formed_messages();
    test_header_errors();
    test_set_errors();
    test_random_streams();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[ipfix_message_set_deframer.f]
design/ipfixd_pkg.sv
design/ipfixd_core.sv
design/ipfixd_res_fifo.sv
design/ipfix_message_set_deframer.sv
tb/sv/testbench.sv
